// File: rtl/h1mp_pkg.sv
// ----------------------------------------------------------------------------
// h1mp_pkg
// Parser state codes, byte classes and character helpers for the message
// byte parser.
// ----------------------------------------------------------------------------
package h1mp_pkg;

  typedef enum logic [5:0] {
    ST_ERR, ST_BEGIN,
    RQ_BEGIN, RQ_METHOD, RQ_TGT_BEGIN, RQ_TGT, RQ_09_LF,
    RQ_H, RQ_T1, RQ_T2, RQ_P, RQ_SLASH, RQ_MAJ, RQ_MIN, RQ_LF,
    RS_H, RS_T1, RS_T2, RS_P, RS_SLASH, RS_MAJ, RS_MIN,
    RS_CODE_BEGIN, RS_CODE, RS_REASON_BEGIN, RS_REASON, RS_LF,
    HD_NAME_BEGIN, HD_NAME, HD_COLON, HD_VAL_BEGIN, HD_VAL, HD_VAL_LF, HD_VAL_END,
    HD_END_LF,
    LW_BEGIN, LW_LF, LW_SPHT_BEGIN, LW_SPHT,
    BD_FIXED, BD_ENDLESS,
    CK_SIZE_BEGIN, CK_SIZE, CK_LF1, CK_BODY, CK_LF2, CK_CR3, CK_LF3
  } state_t;

  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_RESPONSE = 2'd1,
    MODE_HEADERS  = 2'd2
  } mode_t;

  localparam logic [2:0] CLS_FRAME  = 3'd0;
  localparam logic [2:0] CLS_METHOD = 3'd1;
  localparam logic [2:0] CLS_TARGET = 3'd2;
  localparam logic [2:0] CLS_REASON = 3'd3;
  localparam logic [2:0] CLS_NAME   = 3'd4;
  localparam logic [2:0] CLS_VALUE  = 3'd5;
  localparam logic [2:0] CLS_BODY   = 3'd6;
  localparam logic [2:0] CLS_IGNORE = 3'd7;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return c <= 8'd31 || c == 8'd127;
  endfunction

  function automatic logic is_text(input logic [7:0] c);
    return !is_ctl(c) || c == CH_SP || c == CH_HT;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return c <= 8'd127 && !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h48;
      3'd1: r = 8'h54;
      3'd2: r = 8'h54;
      3'd3: r = 8'h50;
      default: r = 8'h2F;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
      4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
      4'd8: r = "l";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
      4'd12: r = "t"; 4'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = "t";  5'd1: r = "r";  5'd2: r = "a";  5'd3: r = "n";
      5'd4: r = "s";  5'd5: r = "f";  5'd6: r = "e";  5'd7: r = "r";
      5'd8: r = "-";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "c";
      5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
      5'd16: r = "g";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ck_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "c"; 3'd1: r = "h"; 3'd2: r = "u"; 3'd3: r = "n";
      3'd4: r = "k"; 3'd5: r = "e"; 3'd6: r = "d";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // x*10+d saturating at cap
  function automatic logic [15:0] dec16(input logic [15:0] x, input logic [3:0] d,
                                        input logic [15:0] cap);
    logic [19:0] t;
    t = ({4'd0, x} << 3) + ({4'd0, x} << 1) + {16'd0, d};
    return (t > {4'd0, cap}) ? cap : t[15:0];
  endfunction

endpackage

// File: rtl/http1_message_byte_parser.sv
// ----------------------------------------------------------------------------
// http1_message_byte_parser
// Byte-wide HTTP/1.x request, response and header-only message parser.
//
// Input channel in_valid/in_ready carries one stream byte per word. Each
// accepted word yields exactly one result word on out_valid/out_ready: the
// byte echoed, its class, event flags, sticky error, version and status.
// The result is registered: out_valid rises in the cycle after acceptance.
// Throughput is one word per cycle; the parse state update is a single pass
// between the input handshake and the result register.
// The result register frees in the cycle it is taken, so in_ready stays high
// while the receiver keeps up; when the receiver stalls, in_ready drops until
// the pending result is taken, and the result holds.
// cfg_wr_en/cfg_wr_data write the parse mode; write it only while idle.
// Reset (rst_n low, synchronous) returns the parser to message start, clears
// the error and empties the result register.
// ----------------------------------------------------------------------------
module http1_message_byte_parser #(
  parameter int LENGTH_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_byte_class,
  output logic        out_msg_begin,
  output logic        out_header_done,
  output logic        out_header_dropped,
  output logic        out_headers_end,
  output logic        out_msg_end,
  output logic        out_proto_error,
  output logic [1:0]  out_http_version,
  output logic [15:0] out_status_value
);

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  logic [1:0] mode_r;

  h1mp_pkg::state_t st_r, st_nxt, fn_r, fn_nxt, fe_r, fe_nxt;
  logic [7:0]    vmaj_r, vmaj_nxt, vmin_r, vmin_nxt;
  logic [15:0]   sacc_r, sacc_nxt;
  logic [LB-1:0] brem_r, brem_nxt, vnum_r, vnum_nxt;
  logic          hlen_r, hlen_nxt, chk_r, chk_nxt;
  logic [4:0]    npos_r, npos_nxt;
  logic [1:0]    nflg_r, nflg_nxt;
  logic [2:0]    vflg_r, vflg_nxt;
  logic [2:0]    cls;
  logic          ev_begin, ev_hdone, ev_hdrop, ev_hend, ev_end, done;
  logic [1:0]    ver_code;
  logic          acc;
  logic [7:0]    c;

  logic          out_valid_r;
  logic [7:0]    obyte_r;
  logic [2:0]    ocls_r;
  logic [4:0]    oev_r;
  logic          oerr_r;
  logic [1:0]    over_r;
  logic [15:0]   ostat_r;

  function automatic logic [LB-1:0] mac10(input logic [LB-1:0] x, input logic [3:0] d);
    logic [LB+3:0] t;
    t = ({4'd0, x} << 3) + ({4'd0, x} << 1) + {{LB{1'b0}}, d};
    return (|t[LB+3:LB]) ? LEN_MAX : t[LB-1:0];
  endfunction

  function automatic logic [LB-1:0] mac16(input logic [LB-1:0] x, input logic [3:0] d);
    logic [LB+3:0] t;
    t = ({4'd0, x} << 4) | {{LB{1'b0}}, d};
    return (|t[LB+3:LB]) ? LEN_MAX : t[LB-1:0];
  endfunction

  function automatic void vfeed(input logic [7:0] ch, inout logic [4:0] pos,
                                inout logic [2:0] fl, inout logic [LB-1:0] num);
    fl[1] = 1'b1;
    if (!(pos < 5'd7 && h1mp_pkg::lower(ch) == h1mp_pkg::ck_char(pos[2:0]))) fl[0] = 1'b0;
    if (!h1mp_pkg::is_digit(ch)) fl[2] = 1'b1;
    else if (!fl[2]) num = mac10(num, ch[3:0]);
    if (pos < 5'd31) pos = pos + 5'd1;
  endfunction

  function automatic void nfeed(input logic [7:0] ch, inout logic [4:0] pos,
                                inout logic [1:0] fl);
    logic [7:0] l;
    l = h1mp_pkg::lower(ch);
    if (!(pos < 5'd14 && l == h1mp_pkg::cl_char(pos[3:0]))) fl[0] = 1'b0;
    if (!(pos < 5'd17 && l == h1mp_pkg::te_char(pos))) fl[1] = 1'b0;
    if (pos < 5'd31) pos = pos + 5'd1;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign c        = in_rx_byte;

  always_comb begin
    st_nxt = st_r; fn_nxt = fn_r; fe_nxt = fe_r;
    vmaj_nxt = vmaj_r; vmin_nxt = vmin_r; sacc_nxt = sacc_r;
    brem_nxt = brem_r; vnum_nxt = vnum_r; hlen_nxt = hlen_r; chk_nxt = chk_r;
    npos_nxt = npos_r; nflg_nxt = nflg_r; vflg_nxt = vflg_r;
    cls = h1mp_pkg::CLS_IGNORE;
    ev_begin = 1'b0; ev_hdone = 1'b0; ev_hdrop = 1'b0; ev_hend = 1'b0; ev_end = 1'b0;
    done = (st_r == h1mp_pkg::ST_ERR);

    if (!done && st_nxt == h1mp_pkg::ST_BEGIN) begin
      hlen_nxt = 1'b0; chk_nxt = 1'b0; brem_nxt = '0;
      vmaj_nxt = '0; vmin_nxt = '0; sacc_nxt = '0;
      case (mode_r)
        h1mp_pkg::MODE_REQUEST:  st_nxt = h1mp_pkg::RQ_BEGIN;
        h1mp_pkg::MODE_RESPONSE: st_nxt = h1mp_pkg::RS_H;
        h1mp_pkg::MODE_HEADERS: begin
          st_nxt = h1mp_pkg::HD_NAME_BEGIN; ev_begin = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end

    if (!done && st_nxt == h1mp_pkg::LW_BEGIN) begin
      if (c == h1mp_pkg::CH_CR) begin
        st_nxt = h1mp_pkg::LW_LF; cls = h1mp_pkg::CLS_FRAME; done = 1'b1;
      end else if (c == h1mp_pkg::CH_SP || c == h1mp_pkg::CH_HT) begin
        st_nxt = h1mp_pkg::LW_SPHT; cls = h1mp_pkg::CLS_FRAME; done = 1'b1;
      end else if (!h1mp_pkg::is_print(c)) begin
        st_nxt = h1mp_pkg::ST_ERR; done = 1'b1;
      end else begin
        st_nxt = fn_r;
      end
    end

    if (!done && st_nxt == h1mp_pkg::LW_SPHT_BEGIN) begin
      if (c == h1mp_pkg::CH_SP || c == h1mp_pkg::CH_HT) begin
        cls = h1mp_pkg::CLS_FRAME;
        if (vflg_nxt[1]) begin
          // folded CR LF and this blank count as three value characters
          vflg_nxt = {2'b11, 1'b0};
          npos_nxt = (npos_nxt > 5'd28) ? 5'd31 : npos_nxt + 5'd3;
          cls = h1mp_pkg::CLS_VALUE;
        end
        st_nxt = h1mp_pkg::LW_SPHT; done = 1'b1;
      end else if (fe_r == h1mp_pkg::ST_ERR) begin
        st_nxt = h1mp_pkg::ST_ERR; done = 1'b1;
      end else begin
        st_nxt = fe_r;
      end
    end

    if (!done && st_nxt == h1mp_pkg::LW_SPHT) begin
      if (c == h1mp_pkg::CH_SP || c == h1mp_pkg::CH_HT) begin
        cls = h1mp_pkg::CLS_FRAME;
        if (vflg_nxt[1]) begin
          vfeed(c, npos_nxt, vflg_nxt, vnum_nxt);
          cls = h1mp_pkg::CLS_VALUE;
        end
        done = 1'b1;
      end else begin
        st_nxt = fn_r;
      end
    end

    if (!done && st_nxt == h1mp_pkg::HD_VAL_END) begin
      ev_hdone = 1'b1;
      if (nflg_nxt[0]) begin
        hlen_nxt = !vflg_nxt[2];
        brem_nxt = vflg_nxt[2] ? '0 : vnum_nxt;
      end else if (nflg_nxt[1] && vflg_nxt[0] && npos_nxt == 5'd7) begin
        chk_nxt = 1'b1; ev_hdrop = 1'b1;
      end
      st_nxt = h1mp_pkg::HD_NAME_BEGIN;
    end

    if (!done && st_nxt == h1mp_pkg::RS_CODE_BEGIN) begin
      if (!h1mp_pkg::is_digit(c)) begin
        st_nxt = h1mp_pkg::ST_ERR; done = 1'b1;
      end else begin
        st_nxt = h1mp_pkg::RS_CODE;
      end
    end

    if (!done && st_nxt == h1mp_pkg::CK_SIZE_BEGIN) begin
      if (!h1mp_pkg::is_hex(c)) begin
        st_nxt = h1mp_pkg::ST_ERR; done = 1'b1;
      end else begin
        brem_nxt = '0; st_nxt = h1mp_pkg::CK_SIZE;
      end
    end

    if (!done) begin
      case (st_nxt)
        h1mp_pkg::RQ_BEGIN: begin
          if (!h1mp_pkg::is_token(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::RQ_METHOD; cls = h1mp_pkg::CLS_METHOD; end
        end
        h1mp_pkg::RQ_METHOD: begin
          if (c == h1mp_pkg::CH_SP) begin
            st_nxt = h1mp_pkg::RQ_TGT_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end else if (h1mp_pkg::is_token(c)) cls = h1mp_pkg::CLS_METHOD;
          else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::RQ_TGT_BEGIN: begin
          if (!h1mp_pkg::is_print(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::RQ_TGT; cls = h1mp_pkg::CLS_TARGET; end
        end
        h1mp_pkg::RQ_TGT: begin
          if (c == h1mp_pkg::CH_SP) begin
            st_nxt = h1mp_pkg::RQ_H; cls = h1mp_pkg::CLS_FRAME;
          end else if (h1mp_pkg::is_print(c)) cls = h1mp_pkg::CLS_TARGET;
          else if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::RQ_09_LF; cls = h1mp_pkg::CLS_FRAME;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::RQ_09_LF: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            vmaj_nxt = 8'd0; vmin_nxt = 8'd9;
            ev_begin = 1'b1; ev_hend = 1'b1; ev_end = 1'b1;
            st_nxt = h1mp_pkg::ST_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::RQ_H, h1mp_pkg::RQ_T1, h1mp_pkg::RQ_T2, h1mp_pkg::RQ_P,
        h1mp_pkg::RQ_SLASH: begin
          if (c != h1mp_pkg::proto_char(3'(st_nxt - h1mp_pkg::RQ_H)))
            st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::state_t'(st_nxt + 6'd1); cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::RS_H, h1mp_pkg::RS_T1, h1mp_pkg::RS_T2, h1mp_pkg::RS_P,
        h1mp_pkg::RS_SLASH: begin
          if (c != h1mp_pkg::proto_char(3'(st_nxt - h1mp_pkg::RS_H)))
            st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::state_t'(st_nxt + 6'd1); cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::RQ_MAJ, h1mp_pkg::RS_MAJ: begin
          if (c == 8'h2E) begin
            st_nxt = h1mp_pkg::state_t'(st_nxt + 6'd1); cls = h1mp_pkg::CLS_FRAME;
          end else if (!h1mp_pkg::is_digit(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            vmaj_nxt = 8'(h1mp_pkg::dec16({8'd0, vmaj_r}, c[3:0], 16'd255));
            cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::RQ_MIN, h1mp_pkg::RS_MIN: begin
          if (st_nxt == h1mp_pkg::RQ_MIN && c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::RQ_LF; cls = h1mp_pkg::CLS_FRAME;
          end else if (st_nxt == h1mp_pkg::RS_MIN && c == h1mp_pkg::CH_SP) begin
            st_nxt = h1mp_pkg::RS_CODE_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end else if (!h1mp_pkg::is_digit(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            vmin_nxt = 8'(h1mp_pkg::dec16({8'd0, vmin_r}, c[3:0], 16'd255));
            cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::RQ_LF, h1mp_pkg::RS_LF: begin
          if (c != h1mp_pkg::CH_LF || ver_code == 2'd0) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            st_nxt = h1mp_pkg::HD_NAME_BEGIN; ev_begin = 1'b1; cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::RS_CODE: begin
          if (h1mp_pkg::is_digit(c)) begin
            sacc_nxt = h1mp_pkg::dec16(sacc_r, c[3:0], 16'hFFFF);
            cls = h1mp_pkg::CLS_FRAME;
          end else if (c == h1mp_pkg::CH_SP) begin
            st_nxt = h1mp_pkg::RS_REASON_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end else if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::RS_LF; cls = h1mp_pkg::CLS_FRAME;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::RS_REASON_BEGIN: begin
          if (!h1mp_pkg::is_text(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::RS_REASON; cls = h1mp_pkg::CLS_REASON; end
        end
        h1mp_pkg::RS_REASON: begin
          if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::RS_LF; cls = h1mp_pkg::CLS_FRAME;
          end else if (h1mp_pkg::is_text(c)) cls = h1mp_pkg::CLS_REASON;
          else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::HD_NAME_BEGIN: begin
          if (h1mp_pkg::is_token(c)) begin
            npos_nxt = '0; nflg_nxt = 2'b11; vflg_nxt = 3'b001; vnum_nxt = '0;
            nfeed(c, npos_nxt, nflg_nxt);
            st_nxt = h1mp_pkg::HD_NAME; cls = h1mp_pkg::CLS_NAME;
          end else if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::HD_END_LF; cls = h1mp_pkg::CLS_FRAME;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::HD_NAME, h1mp_pkg::HD_COLON: begin
          if (st_nxt == h1mp_pkg::HD_NAME && h1mp_pkg::is_token(c)) begin
            nfeed(c, npos_nxt, nflg_nxt); cls = h1mp_pkg::CLS_NAME;
          end else if (c == 8'h3A) begin
            nflg_nxt = nflg_nxt & {npos_nxt == 5'd17, npos_nxt == 5'd14};
            npos_nxt = '0;
            fn_nxt = h1mp_pkg::HD_VAL_BEGIN; fe_nxt = h1mp_pkg::HD_VAL_END;
            st_nxt = h1mp_pkg::LW_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end else if (st_nxt == h1mp_pkg::HD_NAME && c == h1mp_pkg::CH_CR) begin
            fn_nxt = h1mp_pkg::HD_COLON; fe_nxt = h1mp_pkg::ST_ERR;
            st_nxt = h1mp_pkg::LW_LF; cls = h1mp_pkg::CLS_FRAME;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::LW_LF: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::LW_SPHT_BEGIN; cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::HD_VAL_BEGIN: begin
          if (h1mp_pkg::is_text(c)) begin
            vfeed(c, npos_nxt, vflg_nxt, vnum_nxt);
            st_nxt = h1mp_pkg::HD_VAL; cls = h1mp_pkg::CLS_VALUE;
          end else if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::HD_VAL_LF; cls = h1mp_pkg::CLS_FRAME;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::HD_VAL: begin
          if (c == h1mp_pkg::CH_CR) begin
            fn_nxt = h1mp_pkg::HD_VAL; fe_nxt = h1mp_pkg::HD_VAL_END;
            st_nxt = h1mp_pkg::LW_LF; cls = h1mp_pkg::CLS_FRAME;
          end else if (h1mp_pkg::is_text(c)) begin
            vfeed(c, npos_nxt, vflg_nxt, vnum_nxt); cls = h1mp_pkg::CLS_VALUE;
          end else st_nxt = h1mp_pkg::ST_ERR;
        end
        h1mp_pkg::HD_VAL_LF: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::HD_VAL_END; cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::HD_END_LF: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            ev_hend = 1'b1; cls = h1mp_pkg::CLS_FRAME;
            if (chk_nxt) st_nxt = h1mp_pkg::CK_SIZE_BEGIN;
            else if (hlen_nxt) begin
              if (brem_nxt != '0) st_nxt = h1mp_pkg::BD_FIXED;
              else begin ev_end = 1'b1; st_nxt = h1mp_pkg::ST_BEGIN; end
            end else if (mode_r != h1mp_pkg::MODE_REQUEST) st_nxt = h1mp_pkg::BD_ENDLESS;
            else begin ev_end = 1'b1; st_nxt = h1mp_pkg::ST_BEGIN; end
          end
        end
        h1mp_pkg::BD_FIXED: begin
          cls = h1mp_pkg::CLS_BODY;
          if (brem_nxt != '0) brem_nxt = brem_nxt - 1'b1;
          if (brem_nxt == '0) begin ev_end = 1'b1; st_nxt = h1mp_pkg::ST_BEGIN; end
        end
        h1mp_pkg::BD_ENDLESS: cls = h1mp_pkg::CLS_BODY;
        h1mp_pkg::CK_SIZE: begin
          if (c == h1mp_pkg::CH_CR) begin
            st_nxt = h1mp_pkg::CK_LF1; cls = h1mp_pkg::CLS_FRAME;
          end else if (!h1mp_pkg::is_hex(c)) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            brem_nxt = mac16(brem_nxt, h1mp_pkg::hex_nib(c)); cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::CK_LF1: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            st_nxt = (brem_nxt != '0) ? h1mp_pkg::CK_BODY : h1mp_pkg::CK_CR3;
            cls = h1mp_pkg::CLS_FRAME;
          end
        end
        h1mp_pkg::CK_BODY: begin
          if (brem_nxt != '0) begin
            brem_nxt = brem_nxt - 1'b1; cls = h1mp_pkg::CLS_BODY;
          end else if (c != h1mp_pkg::CH_CR) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::CK_LF2; cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::CK_LF2: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::CK_SIZE; cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::CK_CR3: begin
          if (c != h1mp_pkg::CH_CR) st_nxt = h1mp_pkg::ST_ERR;
          else begin st_nxt = h1mp_pkg::CK_LF3; cls = h1mp_pkg::CLS_FRAME; end
        end
        h1mp_pkg::CK_LF3: begin
          if (c != h1mp_pkg::CH_LF) st_nxt = h1mp_pkg::ST_ERR;
          else begin
            ev_end = 1'b1; st_nxt = h1mp_pkg::ST_BEGIN; cls = h1mp_pkg::CLS_FRAME;
          end
        end
        default: st_nxt = h1mp_pkg::ST_ERR;
      endcase
    end

    if (st_nxt == h1mp_pkg::ST_ERR) cls = h1mp_pkg::CLS_IGNORE;
  end

  // version from the current registers (start line check) and next (report)
  function automatic logic [1:0] vcode(input logic [7:0] mj, input logic [7:0] mn);
    logic [1:0] r;
    r = 2'd0;
    if (mj == 8'd0 && mn == 8'd9) r = 2'd1;
    else if (mj == 8'd1 && mn == 8'd0) r = 2'd2;
    else if (mj == 8'd1 && mn == 8'd1) r = 2'd3;
    return r;
  endfunction

  assign ver_code = vcode(vmaj_r, vmin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
      st_r <= h1mp_pkg::ST_BEGIN; fn_r <= h1mp_pkg::ST_ERR; fe_r <= h1mp_pkg::ST_ERR;
      vmaj_r <= '0; vmin_r <= '0; sacc_r <= '0;
      brem_r <= '0; vnum_r <= '0; hlen_r <= 1'b0; chk_r <= 1'b0;
      npos_r <= '0; nflg_r <= 2'b11; vflg_r <= 3'b001;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (acc) begin
        st_r <= st_nxt; fn_r <= fn_nxt; fe_r <= fe_nxt;
        vmaj_r <= vmaj_nxt; vmin_r <= vmin_nxt; sacc_r <= sacc_nxt;
        brem_r <= brem_nxt; vnum_r <= vnum_nxt; hlen_r <= hlen_nxt; chk_r <= chk_nxt;
        npos_r <= npos_nxt; nflg_r <= nflg_nxt; vflg_r <= vflg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      obyte_r <= c;
      ocls_r  <= cls;
      oev_r   <= {ev_end, ev_hend, ev_hdrop, ev_hdone, ev_begin};
      oerr_r  <= (st_nxt == h1mp_pkg::ST_ERR);
      over_r  <= vcode(vmaj_nxt, vmin_nxt);
      ostat_r <= sacc_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = obyte_r;
  assign out_byte_class     = ocls_r;
  assign out_msg_begin      = oev_r[0];
  assign out_header_done    = oev_r[1];
  assign out_header_dropped = oev_r[2];
  assign out_headers_end    = oev_r[3];
  assign out_msg_end        = oev_r[4];
  assign out_proto_error    = oerr_r;
  assign out_http_version   = over_r;
  assign out_status_value   = ostat_r;

endmodule
